[hdl/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, widths and codes for the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // parameter defaults
  localparam int NUM_FRAMES_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int OWNER_BITS_DEF  = 16;

  // fixed field widths
  localparam int BYTES_W   = 20;
  localparam int SHIFT_W   = 5;
  localparam int PAGES_W   = BYTES_W + 1;
  localparam int FIELD_OWN = 16;
  localparam int FIELD_FRM = 5;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 1'd1;

  // configuration reset values
  localparam logic [CFG_DAT_W-1:0] FRAMES_RST = 6'd32;
  localparam logic [SHIFT_W-1:0]   SHIFT_RST  = 5'd12;

  // input kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_GRANT = 3'd0;
  localparam logic [STATUS_W-1:0] ST_READ  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LARGE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd5;

  typedef struct packed {
    logic                 kind;
    logic [FIELD_OWN-1:0] owner;
    logic [BYTES_W-1:0]   segment_bytes;
    logic [FIELD_FRM-1:0] frame_index;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [FIELD_FRM-1:0] frame;
    logic [FIELD_OWN-1:0] frame_owner_id;
    logic                 frame_used;
    logic                 last;
  } out_t;

endpackage

[hdl/pfa_ram.sv]
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/pfa_pages.sv]
// ----------------------------------------------------------------------------
// pfa_pages
// Rounds a byte count up to whole pages for a power-of-two page size.
// ----------------------------------------------------------------------------
module pfa_pages (
  input  logic [pfa_pkg::BYTES_W-1:0] bytes_in,
  input  logic [pfa_pkg::SHIFT_W-1:0] shift,
  output logic [pfa_pkg::PAGES_W-1:0] pages
);
  import pfa_pkg::*;

  logic [BYTES_W-1:0] quot;
  logic [BYTES_W-1:0] rem_mask;
  logic               rem_nz;

  // shifts of 20 or more give a zero quotient and an all-ones mask
  assign quot     = bytes_in >> shift;
  assign rem_mask = ~({BYTES_W{1'b1}} << shift);
  assign rem_nz   = |(bytes_in & rem_mask);
  assign pages    = PAGES_W'(quot) + PAGES_W'(rem_nz);

endmodule

[hdl/page_frame_allocator_fifo_evict_top.sv]
// ----------------------------------------------------------------------------
// page_frame_allocator_fifo_evict_top
// Page frame allocator with FIFO eviction of whole owners.
// ----------------------------------------------------------------------------
// Pulse start with a transaction while busy is low. A read transaction gives
// one result via the S_RD state. An allocate that needs zero pages or more
// pages than the frame count gives one result on the next cycle. Otherwise
// a single frame scanner does all the work, one frame per cycle: a free
// count pass over the effective frames, then for each owner evicted a queue
// pop and an owner-table pass (an empty queue ends it with an empty result),
// then a grant pass that emits one result per frame granted as it finds
// free frames, then the owner is queued unless full. Results come out on
// out_valid for a single cycle each and cannot be held off; last marks the
// final result of a transaction. Configuration writes are always accepted
// (cfg_ready is tied high) and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module page_frame_allocator_fifo_evict_top #(
  parameter int NUM_FRAMES  = pfa_pkg::NUM_FRAMES_DEF,
  parameter int QUEUE_DEPTH = pfa_pkg::QUEUE_DEPTH_DEF,
  parameter int OWNER_BITS  = pfa_pkg::OWNER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  pfa_pkg::in_t                    in_data,
  output logic                            out_valid,
  output pfa_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import pfa_pkg::*;

  localparam int FIDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int QP_W   = $clog2(QUEUE_DEPTH);
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RD     = 9'b000000010,
    S_CNT    = 9'b000000100,
    S_CHK    = 9'b000001000,
    S_POP    = 9'b000010000,
    S_EVICT  = 9'b000100000,
    S_EDRAIN = 9'b001000000,
    S_GRANT  = 9'b010000000,
    S_PUSH   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [CFG_DAT_W-1:0] frames_in_use_r, frames_in_use_nxt;
  logic [SHIFT_W-1:0]   page_shift_r, page_shift_nxt;

  // frame table flags: used, and owner entry written since reset
  logic [NUM_FRAMES-1:0] used_r, used_nxt;
  logic [NUM_FRAMES-1:0] wrv_r, wrv_nxt;

  // eviction queue pointers
  logic [QP_W-1:0] q_head_r, q_head_nxt;
  logic [QP_W-1:0] q_tail_r, q_tail_nxt;
  logic [QC_W-1:0] q_cnt_r, q_cnt_nxt;

  // scan state
  logic [FIDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]      frames_r, frames_nxt;
  logic [CNT_W-1:0]      need_r, need_nxt;
  logic [CNT_W-1:0]      free_r, free_nxt;
  logic [OWNER_BITS-1:0] own_r, own_nxt;
  logic [OWNER_BITS-1:0] victim_r, victim_nxt;
  logic [STATUS_W-1:0]   stat_r, stat_nxt;
  logic                  cmp_v_r, cmp_v_nxt;
  logic [FIDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                  rd_ok_r, rd_ok_nxt;

  // read transaction capture
  logic [FIELD_FRM-1:0] rd_idx_r, rd_idx_nxt;
  logic                 rd_in_r, rd_in_nxt;
  logic                 rd_used_r, rd_used_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;

  // memory ports
  logic                  ow_we, ow_re;
  logic [FIDX_W-1:0]     ow_waddr, ow_raddr;
  logic [OWNER_BITS-1:0] ow_q;
  logic                  q_we, q_re;
  logic [OWNER_BITS-1:0] q_q;

  // combinational helpers
  logic [PAGES_W-1:0]    pages_c;
  logic [CNT_W-1:0]      frames_c;
  logic [CNT_W-1:0]      idx_inc_c;
  logic                  idx_last_c;
  logic [OWNER_BITS-1:0] owner_eff_c;
  logic                  accept_c;
  logic                  rd_range_c;
  logic [FIDX_W-1:0]     in_fidx_c;

  pfa_pages u_pages (
    .bytes_in (in_data.segment_bytes),
    .shift    (page_shift_r),
    .pages    (pages_c)
  );

  // owner table: unwritten entries read as zero through wrv_r
  pfa_ram #(
    .WIDTH (OWNER_BITS),
    .DEPTH (NUM_FRAMES)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ow_we),
    .waddr (ow_waddr),
    .wdata (own_r),
    .re    (ow_re),
    .raddr (ow_raddr),
    .rdata (ow_q)
  );

  // eviction FIFO storage
  pfa_ram #(
    .WIDTH (OWNER_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_tail_r),
    .wdata (own_r),
    .re    (q_re),
    .raddr (q_head_r),
    .rdata (q_q)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept_c  = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // effective frame count, clipped to the table size
  assign frames_c = ({1'b0, frames_in_use_r} > 7'(NUM_FRAMES)) ?
                    CNT_W'(NUM_FRAMES) : CNT_W'(frames_in_use_r);

  assign idx_inc_c   = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_last_c  = (idx_inc_c == frames_r);
  assign owner_eff_c = rd_ok_r ? ow_q : '0;
  assign rd_range_c  = ({2'b00, in_data.frame_index} < 7'(NUM_FRAMES));
  assign in_fidx_c   = FIDX_W'(in_data.frame_index);

  always_comb begin
    state_nxt         = state_r;
    frames_in_use_nxt = frames_in_use_r;
    page_shift_nxt    = page_shift_r;
    used_nxt          = used_r;
    wrv_nxt           = wrv_r;
    q_head_nxt        = q_head_r;
    q_tail_nxt        = q_tail_r;
    q_cnt_nxt         = q_cnt_r;
    idx_nxt           = idx_r;
    frames_nxt        = frames_r;
    need_nxt          = need_r;
    free_nxt          = free_r;
    own_nxt           = own_r;
    victim_nxt        = victim_r;
    stat_nxt          = stat_r;
    cmp_v_nxt         = 1'b0;
    cmp_idx_nxt       = cmp_idx_r;
    rd_ok_nxt         = rd_ok_r;
    rd_idx_nxt        = rd_idx_r;
    rd_in_nxt         = rd_in_r;
    rd_used_nxt       = rd_used_r;
    out_valid_nxt     = 1'b0;
    out_nxt           = out_r;
    ow_we             = 1'b0;
    ow_re             = 1'b0;
    ow_waddr          = idx_r;
    ow_raddr          = idx_r;
    q_we              = 1'b0;
    q_re              = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAMES: frames_in_use_nxt = cfg_data;
        CFG_SHIFT:  page_shift_nxt    = cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end

    // owner compare stage of the eviction pass, in the cycle after the read
    if (cmp_v_r && (owner_eff_c == victim_r)) begin
      used_nxt[cmp_idx_r] = 1'b0;
      if (used_r[cmp_idx_r]) begin
        free_nxt = free_r + CNT_W'(1);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept_c) begin
          if (in_data.kind == KIND_READ) begin
            ow_re       = 1'b1;
            ow_raddr    = in_fidx_c;
            rd_ok_nxt   = wrv_r[in_fidx_c];
            rd_idx_nxt  = in_data.frame_index;
            rd_in_nxt   = rd_range_c;
            rd_used_nxt = rd_range_c & used_r[in_fidx_c];
            state_nxt   = S_RD;
          end else if (pages_c == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ST_ZERO, frame: '0, frame_owner_id: '0,
                              frame_used: 1'b0, last: 1'b1};
          end else if (pages_c > PAGES_W'(frames_c)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ST_LARGE, frame: '0, frame_owner_id: '0,
                              frame_used: 1'b0, last: 1'b1};
          end else begin
            need_nxt   = CNT_W'(pages_c);
            frames_nxt = frames_c;
            own_nxt    = OWNER_BITS'(in_data.owner);
            idx_nxt    = '0;
            free_nxt   = '0;
            state_nxt  = S_CNT;
          end
        end
      end

      S_RD: begin
        out_valid_nxt = 1'b1;
        out_nxt.status         = ST_READ;
        out_nxt.frame          = rd_idx_r;
        out_nxt.frame_owner_id = rd_in_r ? FIELD_OWN'(owner_eff_c) : '0;
        out_nxt.frame_used     = rd_used_r;
        out_nxt.last           = 1'b1;
        state_nxt = S_IDLE;
      end

      S_CNT: begin
        if (!used_r[idx_r]) begin
          free_nxt = free_r + CNT_W'(1);
        end
        if (idx_last_c) begin
          state_nxt = S_CHK;
        end else begin
          idx_nxt = FIDX_W'(idx_inc_c);
        end
      end

      S_CHK: begin
        idx_nxt = '0;
        if (free_r >= need_r) begin
          stat_nxt  = (q_cnt_r >= QC_W'(QUEUE_DEPTH)) ? ST_FULL : ST_GRANT;
          state_nxt = S_GRANT;
        end else if (q_cnt_r == '0) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_EMPTY, frame: '0, frame_owner_id: '0,
                            frame_used: 1'b0, last: 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          q_re       = 1'b1;
          q_head_nxt = (q_head_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 :
                       QP_W'(q_head_r + 1'b1);
          q_cnt_nxt  = q_cnt_r - QC_W'(1);
          state_nxt  = S_POP;
        end
      end

      S_POP: begin
        victim_nxt = q_q;
        state_nxt  = S_EVICT;
      end

      S_EVICT: begin
        ow_re       = 1'b1;
        rd_ok_nxt   = wrv_r[idx_r];
        cmp_v_nxt   = 1'b1;
        cmp_idx_nxt = idx_r;
        if (idx_last_c) begin
          state_nxt = S_EDRAIN;
        end else begin
          idx_nxt = FIDX_W'(idx_inc_c);
        end
      end

      S_EDRAIN: begin
        state_nxt = S_CHK;
      end

      S_GRANT: begin
        idx_nxt = FIDX_W'(idx_inc_c);
        if (!used_r[idx_r]) begin
          used_nxt[idx_r] = 1'b1;
          wrv_nxt[idx_r]  = 1'b1;
          ow_we           = 1'b1;
          need_nxt        = need_r - CNT_W'(1);
          out_valid_nxt   = 1'b1;
          out_nxt.status         = stat_r;
          out_nxt.frame          = FIELD_FRM'(idx_r);
          out_nxt.frame_owner_id = FIELD_OWN'(own_r);
          out_nxt.frame_used     = 1'b1;
          out_nxt.last           = (need_r == CNT_W'(1));
          if (need_r == CNT_W'(1)) begin
            state_nxt = (stat_r == ST_GRANT) ? S_PUSH : S_IDLE;
          end
        end
      end

      S_PUSH: begin
        q_we       = 1'b1;
        q_tail_nxt = (q_tail_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 :
                     QP_W'(q_tail_r + 1'b1);
        q_cnt_nxt  = q_cnt_r + QC_W'(1);
        state_nxt  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      frames_in_use_r <= FRAMES_RST;
      page_shift_r    <= SHIFT_RST;
      used_r          <= '0;
      wrv_r           <= '0;
      q_head_r        <= '0;
      q_tail_r        <= '0;
      q_cnt_r         <= '0;
      cmp_v_r         <= 1'b0;
      out_valid_r     <= 1'b0;
      free_r          <= '0;
      need_r          <= '0;
      frames_r        <= '0;
      idx_r           <= '0;
    end else begin
      state_r         <= state_nxt;
      frames_in_use_r <= frames_in_use_nxt;
      page_shift_r    <= page_shift_nxt;
      used_r          <= used_nxt;
      wrv_r           <= wrv_nxt;
      q_head_r        <= q_head_nxt;
      q_tail_r        <= q_tail_nxt;
      q_cnt_r         <= q_cnt_nxt;
      cmp_v_r         <= cmp_v_nxt;
      out_valid_r     <= out_valid_nxt;
      free_r          <= free_nxt;
      need_r          <= need_nxt;
      frames_r        <= frames_nxt;
      idx_r           <= idx_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    own_r     <= own_nxt;
    victim_r  <= victim_nxt;
    stat_r    <= stat_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    rd_ok_r   <= rd_ok_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rd_in_r   <= rd_in_nxt;
    rd_used_r <= rd_used_nxt;
    out_r     <= out_nxt;
  end

  // the FIFO never holds more owners than it has room for
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QC_W'(QUEUE_DEPTH))
    else $error("eviction queue count above depth");

  // a push only happens when the queue had room at the check
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |-> (q_cnt_r < QC_W'(QUEUE_DEPTH)))
    else $error("push into a full eviction queue");

  // the grant pass never runs past the effective frame count
  a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GRANT) |-> (CNT_W'(idx_r) < frames_r))
    else $error("grant scan ran past the frame count");

  // a granted frame is marked used on the next cycle
  a_grant_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GRANT && !used_r[idx_r]) |=> used_r[$past(idx_r)])
    else $error("granted frame not marked used");

  // free count never exceeds the frames scanned
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (free_r <= frames_r))
    else $error("free frame count above frame count");

endmodule

[sim/tb_page_frame_allocator_fifo_evict_top.sv]
// ----------------------------------------------------------------------------
// tb_page_frame_allocator_fifo_evict_top
// Self-checking bench for the page frame allocator with whole-owner FIFO
// eviction. A frame ledger mirrors the frame table and eviction FIFO, works
// out the result transactions each accepted request should give, and checks
// every strobed result against the oldest one due.
// ----------------------------------------------------------------------------
import pfa_pkg::*;

class frame_alloc_scoreboard;
  logic        used_flag   [NUM_FRAMES_DEF];
  logic [15:0] frame_owner [NUM_FRAMES_DEF];
  logic [15:0] evict_fifo  [QUEUE_DEPTH_DEF];
  int unsigned fifo_head, fifo_tail, fifo_count;
  logic [5:0]  frame_limit;
  logic [4:0]  shift;
  out_t        awaited_results [$];
  int unsigned errors;

  function new();
    foreach (used_flag[i]) begin
      used_flag[i]   = 1'b0;
      frame_owner[i] = '0;
    end
    fifo_head   = 0;
    fifo_tail   = 0;
    fifo_count  = 0;
    frame_limit = FRAMES_RST;
    shift       = SHIFT_RST;
    errors      = 0;
  endfunction

  function int pending();
    return awaited_results.size();
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_FRAMES: frame_limit = data;
      CFG_SHIFT:  shift = data[SHIFT_W-1:0];
      default: ;
    endcase
  endfunction

  function void queue_result(logic [STATUS_W-1:0] code, int unsigned frame,
                             logic [15:0] own, bit used, bit is_last);
    out_t r;
    r.status         = code;
    r.frame          = frame[FIELD_FRM-1:0];
    r.frame_owner_id = own;
    r.frame_used     = used;
    r.last           = is_last;
    awaited_results = {awaited_results, r};
  endfunction

  // Predict every result transaction caused by one accepted request.
  function void add_request(in_t req);
    int unsigned       frames, need, free_cnt;
    longint unsigned   span, pages;
    logic [15:0]       victim;
    logic [STATUS_W-1:0] grant_code;
    if (req.kind == KIND_READ) begin
      queue_result(ST_READ, req.frame_index, frame_owner[req.frame_index],
                   used_flag[req.frame_index], 1'b1);
      return;
    end
    frames = (frame_limit > NUM_FRAMES_DEF) ? NUM_FRAMES_DEF : frame_limit;
    span   = 64'd1 << shift;
    pages  = (longint'(req.segment_bytes) + span - 1) >> shift;
    if (pages == 0) begin
      queue_result(ST_ZERO, 0, '0, 1'b0, 1'b1);
      return;
    end
    if (pages > frames) begin
      queue_result(ST_LARGE, 0, '0, 1'b0, 1'b1);
      return;
    end
    need = pages;
    // evict oldest owners until enough frames are free
    do begin
      free_cnt = 0;
      for (int i = 0; i < frames; i++)
        if (!used_flag[i]) free_cnt++;
      if (free_cnt < need) begin
        if (fifo_count == 0) begin
          queue_result(ST_EMPTY, 0, '0, 1'b0, 1'b1);
          return;
        end
        victim    = evict_fifo[fifo_head];
        fifo_head = (fifo_head + 1) % QUEUE_DEPTH_DEF;
        fifo_count--;
        for (int i = 0; i < frames; i++)
          if (frame_owner[i] == victim) used_flag[i] = 1'b0;
      end
    end while (free_cnt < need);
    grant_code = (fifo_count >= QUEUE_DEPTH_DEF) ? ST_FULL : ST_GRANT;
    for (int i = 0; i < frames && need > 0; i++) begin
      if (!used_flag[i]) begin
        used_flag[i]   = 1'b1;
        frame_owner[i] = req.owner;
        need--;
        queue_result(grant_code, i, req.owner, 1'b1, need == 0);
      end
    end
    if (grant_code == ST_GRANT) begin
      evict_fifo[fifo_tail] = req.owner;
      fifo_tail = (fifo_tail + 1) % QUEUE_DEPTH_DEF;
      fifo_count++;
    end
  endfunction

  function void compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  function void check_result(out_t got);
    out_t want;
    if (awaited_results.size() == 0) begin
      errors++;
      $display("%0t: result with none due, expected nothing, got status %0h frame %0h",
               $time, got.status, got.frame);
      return;
    end
    want = awaited_results.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("frame", want.frame, got.frame);
    compare_field("frame_owner_id", want.frame_owner_id, got.frame_owner_id);
    compare_field("frame_used", want.frame_used, got.frame_used);
    compare_field("last", want.last, got.last);
  endfunction
endclass

module tb_page_frame_allocator_fifo_evict_top;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  in_t                  in_data   = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 busy;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_ready;

  frame_alloc_scoreboard ledger;
  logic [15:0]           owner_pool [6];
  int unsigned           idle_pct = 0;
  bit                    calm     = 1'b0;   // no idling at all in the closing phase

  // 8 time unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  page_frame_allocator_fifo_evict_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Observe every handshake at the clock edge. All bench drives are
  // nonblocking, so values read here are those before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) ledger.add_request(in_data);
      if (cfg_valid && cfg_ready) ledger.write_reg(cfg_index, cfg_data);
      if (out_valid) ledger.check_result(out_data);
    end
  end

  // Safety net: far beyond the slowest legal run.
  initial begin
    #24000000;
    $display("tb_page_frame_allocator_fifo_evict_top failed");
    $finish;
  end

  // --- request builders ------------------------------------------------------

  // allocate; the unused frame index carries random noise
  function automatic in_t alloc_item(logic [15:0] own, logic [BYTES_W-1:0] size);
    in_t it;
    it.kind          = KIND_ALLOC;
    it.owner         = own;
    it.segment_bytes = size;
    it.frame_index   = FIELD_FRM'($urandom);
    return it;
  endfunction

  // read-back; owner and size are don't-care noise
  function automatic in_t read_item(logic [FIELD_FRM-1:0] idx);
    in_t it;
    it.kind          = KIND_READ;
    it.owner         = FIELD_OWN'($urandom);
    it.segment_bytes = BYTES_W'($urandom);
    it.frame_index   = idx;
    return it;
  endfunction

  // A size in bytes that rounds to the given page count under the current
  // shift, where the 20-bit field allows it.
  function automatic logic [BYTES_W-1:0] bytes_for(int unsigned pages);
    longint unsigned lo, hi;
    if (ledger.shift >= BYTES_W) return BYTES_W'($urandom_range(1, 20'hFFFFF));
    lo = ((longint'(pages) - 1) << ledger.shift) + 1;
    hi = longint'(pages) << ledger.shift;
    if (hi > 20'hFFFFF) hi = 20'hFFFFF;
    if (lo > hi) return 20'hFFFFF;
    return BYTES_W'($urandom_range(32'(lo), 32'(hi)));
  endfunction

  // Mostly well-formed allocations from a small owner pool, so owners get
  // queued, evicted and reused; the rest reads, zero sizes and raw sizes.
  function automatic in_t random_item();
    int unsigned roll, frames, cap;
    logic [15:0] own;
    roll   = $urandom_range(0, 99);
    own    = ($urandom_range(0, 99) < 70) ? owner_pool[$urandom_range(0, 5)]
                                          : FIELD_OWN'($urandom);
    frames = (ledger.frame_limit > NUM_FRAMES_DEF) ? NUM_FRAMES_DEF : ledger.frame_limit;
    if (frames == 0)
      cap = 1;
    else if ($urandom_range(0, 3) == 0)
      cap = frames;
    else
      cap = (frames < 6) ? frames : 6;
    if (roll < 15) return read_item(FIELD_FRM'($urandom_range(0, 31)));
    if (roll < 22) return alloc_item(own, '0);
    if (roll < 29) return alloc_item(own, BYTES_W'($urandom));
    return alloc_item(own, bytes_for($urandom_range(1, cap)));
  endfunction

  // --- drivers -----------------------------------------------------------------

  // Hold start with the transaction until accepted; start stays high if the
  // next request follows straight on, else an idle burst may drop it.
  task automatic send(in_t item);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // valid is left high; the caller drops it after the last write
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // Wait for every due result, then let the owner push cycle finish.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic setup(logic [CFG_DAT_W-1:0] frames, logic [SHIFT_W-1:0] shft);
    drain();
    write_cfg(CFG_FRAMES, frames);
    write_cfg(CFG_SHIFT, CFG_DAT_W'(shft));
    cfg_valid <= 1'b0;
  endtask

  // --- run -------------------------------------------------------------------
  initial begin
    ledger = new();
    foreach (owner_pool[i]) owner_pool[i] = FIELD_OWN'($urandom);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: 32 frames, 4 KiB pages.
    idle_pct = 30;
    send(read_item(5'd0));                      // untouched entries read as free
    send(read_item(5'd31));
    send(alloc_item(16'hFFFF, 20'd0));          // zero pages
    send(alloc_item(16'h1234, 20'hFFFFF));      // far too large
    send(alloc_item(16'hFFFF, 20'd1));          // one page
    send(alloc_item(16'h0001, 20'd126976));     // exactly 31 pages, table now full
    send(alloc_item(16'hA5A5, 20'd4097));       // needs two evictions
    send(read_item(5'd0));
    send(read_item(5'd31));
    send(alloc_item(16'h5A5A, 20'd131072));     // whole table in one go
    send(alloc_item(16'h0000, 20'd131073));     // one page over the table

    // No frames at all, byte-sized pages.
    setup(6'd0, 5'd0);
    send(alloc_item(16'h7E7E, 20'd1));          // any nonzero size too large
    send(alloc_item(16'h7E7E, 20'd0));

    // Frame count above the table saturates; huge shift gives one page.
    setup(6'd63, 5'd31);
    send(alloc_item(16'h3C3C, 20'hFFFFF));
    send(read_item(5'd0));

    // Single frame.
    setup(6'd1, 5'd0);
    send(alloc_item(16'hC3C3, 20'd1));
    send(alloc_item(16'hC3C3, 20'd2));          // too large for one frame
    send(alloc_item(16'h8001, 20'd1));          // evicts the previous owner

    setup(6'd33, 5'd16);
    send(alloc_item(16'h4242, 20'd131073));     // three 64 KiB pages

    // Fill the eviction FIFO: one owner, one page at a time, so each
    // eviction frees the whole table and pushes outrun pops until full.
    setup(6'd32, 5'd12);
    idle_pct = 25;
    repeat (70) send(alloc_item(owner_pool[0], bytes_for(1)));
    // Full FIFO: grants that skip the push.
    repeat (5)
      send(alloc_item(owner_pool[$urandom_range(1, 2)], bytes_for($urandom_range(1, 3))));

    // Random phases over a spread of settings.
    setup(6'($urandom_range(2, 31)), 5'($urandom_range(0, 16)));
    idle_pct = 40;
    repeat (3) send(random_item());

    setup(6'($urandom_range(33, 63)), 5'($urandom_range(17, 31)));
    idle_pct = 0;                               // back-to-back stretch
    repeat (3) send(random_item());

    setup(6'd4, 5'd3);
    idle_pct = 30;
    repeat (3) send(random_item());

    setup(6'd32, 5'd12);
    calm = 1'b1;
    repeat (3) send(random_item());

    drain();
    repeat (40) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0)
      $display("tb_page_frame_allocator_fifo_evict_top passed");
    else
      $display("tb_page_frame_allocator_fifo_evict_top failed");
    $finish;
  end

endmodule

[page_frame_allocator_fifo_evict_top.f]
hdl/pfa_pkg.sv
hdl/pfa_ram.sv
hdl/pfa_pages.sv
hdl/page_frame_allocator_fifo_evict_top.sv
sim/tb_page_frame_allocator_fifo_evict_top.sv
